/* rtl/cfs_pkg.sv */
// cfs_pkg: shared constants and the result record of the circular FIFO with search.
// Used by cfs_ctrl and circular_fifo_with_search_top. No dependencies.
package cfs_pkg;

  // Build defaults
  localparam int DEPTH_DEF     = 32;
  localparam int WORD_BITS_DEF = 32;

  // Fixed field widths
  localparam int CAP_BITS  = 6;
  localparam int OP_BITS   = 3;
  localparam int STAT_BITS = 2;
  localparam int SLOT_BITS = 5;
  localparam int DATA_BITS = 32;

  // Slots used when capacity is written as zero
  localparam logic [CAP_BITS-1:0] DEFAULT_SLOTS = 6'd20;

  // Command codes
  localparam logic [OP_BITS-1:0] OP_ENQ    = 3'd0;
  localparam logic [OP_BITS-1:0] OP_DEQ    = 3'd1;
  localparam logic [OP_BITS-1:0] OP_SEARCH = 3'd2;
  localparam logic [OP_BITS-1:0] OP_CLEAR  = 3'd3;
  localparam logic [OP_BITS-1:0] OP_PEEKF  = 3'd4;
  localparam logic [OP_BITS-1:0] OP_PEEKR  = 3'd5;

  // Status codes
  localparam logic [STAT_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_BITS-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_BITS-1:0] ST_EMPTY = 2'd2;

  // Data word returned by a peek of an empty queue
  localparam logic [DATA_BITS-1:0] EMPTY_WORD = '1;

  // One result beat
  typedef struct packed {
    logic [STAT_BITS-1:0] status;
    logic [DATA_BITS-1:0] data;
    logic                 found;
    logic [SLOT_BITS-1:0] slot;
    logic [CAP_BITS-1:0]  occ;
  } res_t;

endpackage

/* rtl/cfs_ram.sv */
// cfs_ram: ring storage, one write port and one read port with registered read data.
// Standalone; no package dependencies.
module cfs_ram #(
  parameter int DEPTH     = 32,
  parameter int WORD_BITS = 32,
  parameter int AW        = 5
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [WORD_BITS-1:0] wr_data,
  input  logic [AW-1:0]        rd_addr,
  output logic [WORD_BITS-1:0] rd_data
);

  logic [WORD_BITS-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/cfs_ctrl.sv */
// cfs_ctrl: command register, queue pointers and sequencer for the circular FIFO.
// Depends on cfs_pkg; drives the ports of cfs_ram.
module cfs_ctrl #(
  parameter int DEPTH     = cfs_pkg::DEPTH_DEF,
  parameter int WORD_BITS = cfs_pkg::WORD_BITS_DEF,
  parameter int AW        = $clog2(DEPTH)
) (
  input  logic                           clk,
  input  logic                           rst,
  // command beat
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [cfs_pkg::OP_BITS-1:0]    opcode,
  input  logic signed [31:0]             value,
  // capacity write
  input  logic                           cfg_wr,
  input  logic [cfs_pkg::CAP_BITS-1:0]   cfg_data,
  // result hand-off
  input  logic                           out_free,
  output logic                           res_load,
  output cfs_pkg::res_t                  res,
  // ring storage
  output logic                           wr_en,
  output logic [AW-1:0]                  wr_addr,
  output logic [WORD_BITS-1:0]           wr_data,
  output logic [AW-1:0]                  rd_addr,
  input  logic [WORD_BITS-1:0]           rd_data
);

  localparam int CB = cfs_pkg::CAP_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_PEEK = 2'd2;
  localparam logic [1:0] S_SCAN = 2'd3;

  logic [1:0]                   state, state_next;
  logic [1:0]                   state_seq;
  logic [cfs_pkg::OP_BITS-1:0]  cmd_op;
  logic [WORD_BITS-1:0]         cmd_word;
  logic [CB-1:0]                cap_reg;
  logic [AW-1:0]                head, head_next;
  logic [AW-1:0]                tail, tail_next;
  logic [CB-1:0]                count, count_next;
  logic [AW-1:0]                ptr, ptr_next;
  logic [CB-1:0]                left, left_next;

  logic [CB-1:0]                slots;
  logic                         accept;
  logic                         done;
  logic                         empty;
  logic                         hit;
  logic [63:0]                  value_ext;
  logic signed [WORD_BITS-1:0]  rd_signed;
  logic [63:0]                  rd_ext;
  logic [31:0]                  ptr_wide;
  logic [AW-1:0]                rear;
  logic [AW-1:0]                ptr_adv;

  // Step to the next ring slot, wrapping at the slots in use
  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] i,
                                              input logic [CB-1:0] c);
    logic [AW:0] n;
    n = {1'b0, i} + 1'b1;
    if (32'(n) >= 32'(c)) begin
      return '0;
    end
    return n[AW-1:0];
  endfunction

  // Slots in use: zero means the default, clamp to the built depth
  always_comb begin
    slots = (cap_reg == '0) ? cfs_pkg::DEFAULT_SLOTS : cap_reg;
    if (32'(slots) > DEPTH) begin
      slots = CB'(DEPTH);
    end
  end

  // Word conversions between the 32-bit ports and the stored width
  assign value_ext = {32'b0, value};
  assign rd_signed = rd_data;
  assign rd_ext    = 64'(rd_signed);
  assign ptr_wide  = 32'(ptr);

  assign empty   = (count == '0);
  assign hit     = (rd_data == cmd_word);
  assign rear    = (tail == '0) ? AW'(slots - 1'b1) : tail - 1'b1;
  assign ptr_adv = next_slot(ptr, slots);

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE) && !done;
  assign res_load = done;

  assign wr_addr = tail;
  assign wr_data = cmd_word;

  // Sequence one command: execute, then wait on a read or walk the ring
  always_comb begin
    state_seq  = state;
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    ptr_next   = ptr;
    left_next  = left;
    rd_addr    = ptr;
    wr_en      = 1'b0;
    done       = 1'b0;
    res        = '0;

    case (state)
      S_EXEC: begin
        case (cmd_op)
          cfs_pkg::OP_ENQ: begin
            done = out_free;
            if (count >= slots) begin
              res.status = cfs_pkg::ST_FULL;
            end else begin
              wr_en      = done;
              tail_next  = next_slot(tail, slots);
              count_next = count + 1'b1;
            end
          end
          cfs_pkg::OP_DEQ: begin
            done = out_free;
            if (empty) begin
              res.status = cfs_pkg::ST_EMPTY;
            end else if (count == CB'(1)) begin
              head_next  = '0;
              tail_next  = '0;
              count_next = '0;
            end else begin
              head_next  = next_slot(head, slots);
              count_next = count - 1'b1;
            end
          end
          cfs_pkg::OP_SEARCH: begin
            if (empty) begin
              done       = out_free;
              res.status = cfs_pkg::ST_EMPTY;
            end else begin
              rd_addr    = head;
              ptr_next   = head;
              left_next  = count;
              state_seq  = S_SCAN;
            end
          end
          cfs_pkg::OP_CLEAR: begin
            done       = out_free;
            res.status = empty ? cfs_pkg::ST_EMPTY : cfs_pkg::ST_OK;
            head_next  = '0;
            tail_next  = '0;
            count_next = '0;
          end
          cfs_pkg::OP_PEEKF, cfs_pkg::OP_PEEKR: begin
            if (empty) begin
              done       = out_free;
              res.status = cfs_pkg::ST_EMPTY;
              res.data   = cfs_pkg::EMPTY_WORD;
            end else begin
              rd_addr    = (cmd_op == cfs_pkg::OP_PEEKR) ? rear : head;
              ptr_next   = rd_addr;
              state_seq  = S_PEEK;
            end
          end
          default: begin
            done = out_free;
          end
        endcase
      end

      // Read data of the peeked slot is valid; hold the address while stalled
      S_PEEK: begin
        done     = out_free;
        res.data = rd_ext[31:0];
      end

      // Compare the slot read last cycle; stop on a hit or the last stored word
      S_SCAN: begin
        if (hit || left == CB'(1)) begin
          done      = out_free;
          res.found = hit;
          res.slot  = hit ? ptr_wide[cfs_pkg::SLOT_BITS-1:0] : '0;
        end else begin
          rd_addr   = ptr_adv;
          ptr_next  = ptr_adv;
          left_next = left - 1'b1;
        end
      end

      default: begin
      end
    endcase

    res.occ = count_next;
  end

  // Finish, or take the next command in the same cycle
  always_comb begin
    if (accept) begin
      state_next = S_EXEC;
    end else if (done) begin
      state_next = S_IDLE;
    end else begin
      state_next = state_seq;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cap_reg <= cfs_pkg::DEFAULT_SLOTS;
      head    <= '0;
      tail    <= '0;
      count   <= '0;
    end else begin
      state <= state_next;
      if (done) begin
        head  <= head_next;
        tail  <= tail_next;
        count <= count_next;
      end
      // Capacity write empties the queue
      if (cfg_wr) begin
        cap_reg <= cfg_data;
        head    <= '0;
        tail    <= '0;
        count   <= '0;
      end
    end
  end

  // Command and walk registers
  always_ff @(posedge clk) begin
    ptr  <= ptr_next;
    left <= left_next;
    if (accept) begin
      cmd_op   <= opcode;
      cmd_word <= value_ext[WORD_BITS-1:0];
    end
  end

endmodule

/* rtl/circular_fifo_with_search_top.sv */
// circular_fifo_with_search_top: ring-buffer FIFO of signed words with search.
// Depends on cfs_pkg, cfs_ctrl and cfs_ram.
//
//   channel   handshake             payload
//   in        in_valid / in_stall   opcode, value
//   out       out_valid / out_stall status, data_out, found, found_slot, occupancy
//   cfg       cfg_valid / cfg_ready cfg_data (capacity)
//
// Enqueue, dequeue, clear and refused commands finish in the execute state, back to back
// while the output is free. Peek reads in execute and returns the word in the peek state;
// search compares slots one per cycle through the single read port of the ring memory.
// A result is loaded into the output register at the edge that finishes its command.
// Reset empties the queue and sets capacity to 20; ring contents are not cleared.
// A stalled result holds; one more command is taken and waits for the output register.
module circular_fifo_with_search_top #(
  parameter int DEPTH     = cfs_pkg::DEPTH_DEF,
  parameter int WORD_BITS = cfs_pkg::WORD_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [cfs_pkg::OP_BITS-1:0]          opcode,
  input  logic signed [31:0]                   value,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [cfs_pkg::STAT_BITS-1:0]        status,
  output logic signed [31:0]                   data_out,
  output logic                                 found,
  output logic [cfs_pkg::SLOT_BITS-1:0]        found_slot,
  output logic [cfs_pkg::CAP_BITS-1:0]         occupancy,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [cfs_pkg::CAP_BITS-1:0]         cfg_data
);

  localparam int AW = $clog2(DEPTH);

  logic                  out_free;
  logic                  res_load;
  cfs_pkg::res_t         res;
  cfs_pkg::res_t         out_res;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [WORD_BITS-1:0]  wr_data;
  logic [AW-1:0]         rd_addr;
  logic [WORD_BITS-1:0]  rd_data;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;

  cfs_ctrl #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS),
    .AW        (AW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .opcode   (opcode),
    .value    (value),
    .cfg_wr   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .out_free (out_free),
    .res_load (res_load),
    .res      (res),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  cfs_ram #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS),
    .AW        (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Output register: load a finished result, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res <= res;
    end
  end

  assign status     = out_res.status;
  assign data_out   = out_res.data;
  assign found      = out_res.found;
  assign found_slot = out_res.slot;
  assign occupancy  = out_res.occ;

  // A waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !res_load)
    else $error("result loaded over a stalled beat");

  // A rejected enqueue implies a nonempty queue
  a_full_nonempty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == cfs_pkg::ST_FULL) |-> (occupancy != '0))
    else $error("full status with zero occupancy");

  // An empty status always comes with the queue left empty
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == cfs_pkg::ST_EMPTY) |-> (occupancy == '0))
    else $error("empty status with nonzero occupancy");

  // A search hit only comes with status ok
  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> (status == cfs_pkg::ST_OK))
    else $error("found flag with a refusal status");

endmodule
